// ===== rtl/vfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_pkg: shared types and constants of the varint / fixed-width serializer
// Holds the beat types of both channels, the job type that travels between
// the front end and the byte engine, and the format codes.
// ----------------------------------------------------------------------------
package vfs_pkg;

    // Format codes of an input item.
    localparam logic [2:0] FMT_FIX8   = 3'd0;
    localparam logic [2:0] FMT_FIX16  = 3'd1;
    localparam logic [2:0] FMT_FIX32  = 3'd2;
    localparam logic [2:0] FMT_FIX64  = 3'd3;
    localparam logic [2:0] FMT_UVAR32 = 3'd4;
    localparam logic [2:0] FMT_SVAR32 = 3'd5;
    localparam logic [2:0] FMT_UVAR64 = 3'd6;
    localparam logic [2:0] FMT_SVAR64 = 3'd7;

    // Varint group mask and continuation bit.
    localparam logic [7:0] GROUP_MASK = 8'h7f;
    localparam logic [7:0] CONT_BIT   = 8'h80;

    // Configuration register byte addresses.
    localparam logic [2:0] ADDR_BYTE_ORDER = 3'd0;

    typedef struct packed {
        logic [2:0]  format_code;
        logic [63:0] value;
    } vfs_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } vfs_out_t;

    // One classified item: the word is always drained low end first.
    typedef struct packed {
        logic [63:0] word;
        logic        is_var;
        logic [2:0]  cnt;      // fixed formats: bytes left minus one
    } vfs_job_t;

endpackage

// ===== rtl/vfs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_front: input stage
// Accepts an item, applies masking, zigzag and byte ordering, and holds the
// resulting job in a register until the queue takes it.
// ----------------------------------------------------------------------------
module vfs_front import vfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     lsb_first,
    input  logic     item_valid,
    output logic     item_ready,
    input  vfs_in_t  item,
    output logic     job_valid,
    input  logic     job_ready,
    output vfs_job_t job
);

    logic     valid_reg;
    logic     valid_next;
    vfs_job_t job_reg;
    vfs_job_t job_next;
    logic     take;

    // Reverses the lowest nbytes bytes of a word; upper bytes come out zero.
    function automatic logic [63:0] swap_bytes(input logic [63:0] w, input int nbytes);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (k < nbytes)
            begin
                r[8*k +: 8] = w[8*(nbytes-1-k) +: 8];
            end
        end
        return r;
    endfunction

    assign item_ready = !valid_reg || job_ready;
    assign take       = item_valid && item_ready;
    assign job_valid  = valid_reg;
    assign job        = job_reg;

    always_comb
    begin
        job_next        = '0;
        job_next.is_var = item.format_code[2];
        unique case (item.format_code)
            FMT_FIX8:
            begin
                job_next.word = {56'd0, item.value[7:0]};
                job_next.cnt  = 3'd0;
            end
            FMT_FIX16:
            begin
                job_next.word = lsb_first ? {48'd0, item.value[15:0]}
                                          : swap_bytes(item.value, 2);
                job_next.cnt  = 3'd1;
            end
            FMT_FIX32:
            begin
                job_next.word = lsb_first ? {32'd0, item.value[31:0]}
                                          : swap_bytes(item.value, 4);
                job_next.cnt  = 3'd3;
            end
            FMT_FIX64:
            begin
                job_next.word = lsb_first ? item.value : swap_bytes(item.value, 8);
                job_next.cnt  = 3'd7;
            end
            FMT_UVAR32:
            begin
                job_next.word = {32'd0, item.value[31:0]};
            end
            FMT_SVAR32:
            begin
                job_next.word = {32'd0, {item.value[30:0], 1'b0} ^ {32{item.value[31]}}};
            end
            FMT_UVAR64:
            begin
                job_next.word = item.value;
            end
            FMT_SVAR64:
            begin
                job_next.word = {item.value[62:0], 1'b0} ^ {64{item.value[63]}};
            end
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (job_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== rtl/vfs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_fifo: job queue
// A short first-in first-out queue that decouples the front end from the
// byte engine. The head entry is shown combinationally.
// ----------------------------------------------------------------------------
module vfs_fifo import vfs_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  vfs_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output vfs_job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vfs_job_t             entries_reg [DEPTH];
    logic     [PTR_W-1:0] wr_ptr_reg;
    logic     [PTR_W-1:0] wr_ptr_next;
    logic     [PTR_W-1:0] rd_ptr_reg;
    logic     [PTR_W-1:0] rd_ptr_next;
    logic     [CNT_W-1:0] count_reg;
    logic     [CNT_W-1:0] count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/vfs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_back: byte engine
// Drains one job a byte per cycle, unless res_ready stalls it, into an
// output register, as fixed bytes or as varint groups with continuation bits.
// ----------------------------------------------------------------------------
module vfs_back import vfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  vfs_job_t job,
    output logic     res_valid,
    input  logic     res_ready,
    output vfs_out_t res
);

    logic     cur_valid_reg;
    logic     cur_valid_next;
    vfs_job_t cur_reg;
    logic     res_valid_reg;
    logic     res_valid_next;
    vfs_out_t res_reg;
    vfs_out_t beat;
    logic     emit;

    assign emit      = cur_valid_reg && (!res_valid_reg || res_ready);
    assign job_ready = !cur_valid_reg || (emit && beat.last);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        if (cur_reg.is_var)
        begin
            beat.last     = (cur_reg.word[63:7] == '0);
            beat.out_byte = (cur_reg.word[7:0] & GROUP_MASK) | (beat.last ? 8'h00 : CONT_BIT);
        end
        else
        begin
            beat.last     = (cur_reg.cnt == 3'd0);
            beat.out_byte = cur_reg.word[7:0];
        end
    end

    always_comb
    begin
        if (job_valid && job_ready)
        begin
            cur_valid_next = 1'b1;
        end
        else if (emit && beat.last)
        begin
            cur_valid_next = 1'b0;
        end
        else
        begin
            cur_valid_next = cur_valid_reg;
        end

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            cur_reg <= job;
        end
        else if (emit)
        begin
            cur_reg.word <= cur_reg.is_var ? {7'd0, cur_reg.word[63:7]}
                                           : {8'd0, cur_reg.word[63:8]};
            cur_reg.cnt  <= cur_reg.cnt - 3'd1;
        end
        if (emit)
        begin
            res_reg <= beat;
        end
    end

endmodule

// ===== rtl/varint_fixint_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_fixint_serializer: fixed-width and varint byte serializer
// Turns one value and a format code into its serialized byte stream.
// ----------------------------------------------------------------------------
// Usage:
// An input beat on item carries a format code and a 64-bit value. The block
// answers with 1 to 10 output beats on res, one byte each, in stream order;
// the final byte of an item has last set. Fixed formats give 1, 2, 4 or 8
// bytes, big endian unless the byte-order register at APB address 0 is set.
// Varints give 7-bit groups low group first with 0x80 marking that another
// byte follows; the signed varints are zigzag mapped first.
// From the edge that accepts an item, the item passes the input register,
// the job queue, the byte engine's load and its output register in that
// order before its first byte shows on res.
// Throughput is one byte per cycle while res_ready is high, set by the
// byte engine, also across item boundaries. New items keep being accepted
// while the engine drains earlier ones, until queue and input register fill.
// Reset clears all valid flags and sets the byte order to big endian. When
// the receiver holds res_ready low, the output register keeps its byte, the
// engine waits, and the queue and input register fill before item_ready drops.
// ----------------------------------------------------------------------------
module varint_fixint_serializer import vfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  vfs_in_t     item,
    output logic        res_valid,
    input  logic        res_ready,
    output vfs_out_t    res
);

    logic     lsb_first_reg;
    logic     lsb_first_next;
    logic     cfg_write;
    logic     fj_valid;
    logic     fj_ready;
    vfs_job_t fj;
    logic     bj_valid;
    logic     bj_ready;
    vfs_job_t bj;

    // Configuration: one register, written in the APB access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ADDR_BYTE_ORDER) ? {31'd0, lsb_first_reg} : 32'd0;

    always_comb
    begin
        lsb_first_next = lsb_first_reg;
        if (cfg_write && (paddr == ADDR_BYTE_ORDER))
        begin
            lsb_first_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsb_first_reg <= 1'b0;
        end
        else
        begin
            lsb_first_reg <= lsb_first_next;
        end
    end

    // Front end: classifies the item and prepares the word to drain.
    vfs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .lsb_first  (lsb_first_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (fj_valid),
        .job_ready  (fj_ready),
        .job        (fj)
    );

    // Job queue between the two halves.
    vfs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_job   (fj),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_job    (bj)
    );

    // Back end: emits one byte per cycle into the output register while not stalled.
    vfs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ===== rtl/vfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_checker: port-level checks of the serializer
// Watches both channels and checks handshake rules, byte counts per item
// and that no byte appears without an outstanding item.
// ----------------------------------------------------------------------------
module vfs_checker import vfs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input vfs_in_t     item,
    input logic        res_valid,
    input logic        res_ready,
    input vfs_out_t    res
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic [3:0] bytes_reg;
    logic [3:0] bytes_next;
    logic       in_fire;
    logic       last_fire;

    assign in_fire   = item_valid && item_ready;
    assign last_fire = res_valid && res_ready && res.last;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_fire && !last_fire)
        begin
            pending_next = pending_reg + 8'd1;
        end
        else if (last_fire && !in_fire)
        begin
            pending_next = pending_reg - 8'd1;
        end
        bytes_next = bytes_reg;
        if (res_valid && res_ready)
        begin
            bytes_next = res.last ? 4'd0 : bytes_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            bytes_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            bytes_reg   <= bytes_next;
        end
    end

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("item beat dropped or changed while stalled");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat dropped or changed while stalled");

    a_max_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.last |-> bytes_reg < 4'd9)
        else $error("item encoding longer than ten bytes");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 8'd0)
        else $error("result beat without an outstanding item");

endmodule

bind varint_fixint_serializer vfs_checker u_vfs_checker (.*);
